[src/key_value_table_linear_macros.svh]
// Assertion macros for the key/value table.
`ifndef KEY_VALUE_TABLE_LINEAR_MACROS_SVH
`define KEY_VALUE_TABLE_LINEAR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define KVT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kvt assertion failed");
`define KVT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("kvt forbidden condition seen");
`else
`define KVT_ASSERT(label, clk, rst_n, prop)
`define KVT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[src/kvt_pkg.sv]
// Types, sizes and codes shared by the key/value table.
package kvt_pkg;

  localparam int ENTRIES  = 128;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        key;
    logic signed [31:0] value;
  } kvt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         entry_count;
  } kvt_rsp_t;

endpackage

[src/kvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/key_value_table_linear.sv]
// Linear-search key/value table: sequencer around a key RAM and a value RAM.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+--------------------------------------
//  command  | start, busy, req_i        | word taken when start && !busy
//  result   | done_o, rsp_o             | one-cycle strobe, no back-pressure
//
// Clear finishes in idle, so busy stays low. Other commands scan entries
// from 0 up at one key per cycle through the RAM read port; a hit ends the
// scan at its entry, a miss once the last live entry is compared. A remove
// that leaves a hole then moves the last entry into it via S_MOVE_RD and
// S_MOVE_WR. The result strobe comes the cycle after the decision, while
// busy is already low. Reset clears state, count and flags; RAM contents stay.
`include "key_value_table_linear_macros.svh"

module key_value_table_linear
  import kvt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  kvt_req_t req_i,
  output logic     done_o,
  output kvt_rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_MOVE_RD = 2'd2;
  localparam logic [1:0] S_MOVE_WR = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             cmp_v_q, cmp_v_d;
  logic             done_q, done_d;
  kvt_req_t         cmd_q, cmd_d;
  kvt_rsp_t         rsp_q, rsp_d;

  logic [IDX_W-1:0]    raddr, waddr;
  logic                key_we, val_we;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;
  logic [31:0]         val_wdata, val_rdata;

  logic [CNT_W-1:0] last_idx;
  logic             key_hit, scan_end, issue;

  kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  kvt_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  assign last_idx = count_q - 1'b1;
  assign issue    = (rd_idx_q < count_q);
  assign key_hit  = cmp_v_q && (key_rdata == cmd_q.key[KEY_BITS-1:0]);
  // miss: empty table, or the last live entry compared without a match
  assign scan_end = (count_q == '0) || (cmp_v_q && (cmp_idx_q == last_idx));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    pos_d     = pos_q;
    cmp_v_d   = 1'b0;
    done_d    = 1'b0;
    cmd_d     = cmd_q;
    rsp_d     = rsp_q;
    raddr     = rd_idx_q[IDX_W-1:0];
    waddr     = cmp_idx_q[IDX_W-1:0];
    key_we    = 1'b0;
    val_we    = 1'b0;
    key_wdata = cmd_q.key[KEY_BITS-1:0];
    val_wdata = cmd_q.value;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = req_i;
          rd_idx_d = '0;
          if (req_i.func == OP_CLEAR) begin
            count_d                = '0;
            done_d                 = 1'b1;
            rsp_d.status           = ST_OK;
            rsp_d.read_value       = '0;
            rsp_d.entry_count      = '0;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read one entry per cycle; data compares in the next cycle
        cmp_v_d   = issue;
        cmp_idx_d = rd_idx_q;
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        rsp_d.read_value  = '0;
        rsp_d.entry_count = 8'(count_q);
        if (key_hit) begin
          rsp_d.status = ST_OK;
          case (cmd_q.func)
            OP_PUT: begin
              val_we  = 1'b1;
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
            OP_GET: begin
              rsp_d.read_value = val_rdata;
              state_d          = S_IDLE;
              done_d           = 1'b1;
            end
            OP_REMOVE: begin
              if (cmp_idx_q == last_idx) begin
                count_d           = last_idx;
                rsp_d.entry_count = 8'(last_idx);
                state_d           = S_IDLE;
                done_d            = 1'b1;
              end else begin
                pos_d   = cmp_idx_q;
                state_d = S_MOVE_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
          endcase
        end else if (scan_end) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (cmd_q.func == OP_PUT) begin
            if (count_q < CNT_W'(ENTRIES)) begin
              waddr             = count_q[IDX_W-1:0];
              key_we            = 1'b1;
              val_we            = 1'b1;
              count_d           = count_q + 1'b1;
              rsp_d.status      = ST_INSERTED;
              rsp_d.entry_count = 8'(count_q + 1'b1);
            end else begin
              rsp_d.status = ST_FULL;
            end
          end else begin
            rsp_d.status = ST_NOT_FOUND;
          end
        end
      end

      S_MOVE_RD: begin
        raddr   = last_idx[IDX_W-1:0];
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // last entry fills the hole left by the removed key
        waddr             = pos_q[IDX_W-1:0];
        key_wdata         = key_rdata;
        val_wdata         = val_rdata;
        key_we            = 1'b1;
        val_we            = 1'b1;
        count_d           = last_idx;
        rsp_d.status      = ST_OK;
        rsp_d.read_value  = '0;
        rsp_d.entry_count = 8'(last_idx);
        state_d           = S_IDLE;
        done_d            = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cmp_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cmp_v_q <= cmp_v_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    pos_q     <= pos_d;
    cmd_q     <= cmd_d;
    rsp_q     <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `KVT_ASSERT(a_accept_progress, clk_i, rst_ni, start && !busy |=> busy || done_o)
  `KVT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(ENTRIES))
  `KVT_ASSERT(a_full_only_when_full, clk_i, rst_ni, done_o && rsp_o.status == ST_FULL |-> count_q == CNT_W'(ENTRIES))
  `KVT_ASSERT(a_value_only_on_hit, clk_i, rst_ni, done_o && rsp_o.status != ST_OK |-> rsp_o.read_value == '0)

endmodule
